/* rtl/i2c_master_transaction_engine_assert.svh */
// Assertion macros shared by the I2C master RTL.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define I2CM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm check failed");
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm check failed");
`else
`define I2CM_ASSERT_NOW(lbl, ante, cons)
`define I2CM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/i2cm_pkg.sv */
// Package for the I2C master transaction engine: request/result types,
// action, status and bus phase codes. No dependencies.
package i2cm_pkg;

  localparam int FIFO_DEPTH = 16;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;
  localparam logic [1:0] ST_BAD_LEN   = 2'd3;

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_S1       = 5'd1;
  localparam logic [4:0] PH_S2       = 5'd2;
  localparam logic [4:0] PH_S3       = 5'd3;
  localparam logic [4:0] PH_S4       = 5'd4;
  localparam logic [4:0] PH_TX_SETUP = 5'd5;
  localparam logic [4:0] PH_TX_HIGH  = 5'd6;
  localparam logic [4:0] PH_TX_LOW   = 5'd7;
  localparam logic [4:0] PH_TX_REL   = 5'd8;
  localparam logic [4:0] PH_ACK_HIGH = 5'd9;
  localparam logic [4:0] PH_ACK_LOW  = 5'd10;
  localparam logic [4:0] PH_RX_HIGH  = 5'd11;
  localparam logic [4:0] PH_RX_LOW   = 5'd12;
  localparam logic [4:0] PH_MA_SETUP = 5'd13;
  localparam logic [4:0] PH_MA_HIGH  = 5'd14;
  localparam logic [4:0] PH_MA_LOW   = 5'd15;
  localparam logic [4:0] PH_MA_REL   = 5'd16;
  localparam logic [4:0] PH_P1       = 5'd17;
  localparam logic [4:0] PH_P2       = 5'd18;
  localparam logic [4:0] PH_P3       = 5'd19;

  typedef struct packed {
    logic [1:0] action;
    logic       sda_in;
    logic [7:0] data_byte;
    logic [6:0] dev_address;
    logic       read_not_write;
    logic [7:0] byte_count;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
    logic [4:0] fifo_level;
  } rsp_t;

endpackage

/* rtl/i2cm_stream_if.sv */
// Valid/ready channel carrying one request or result payload.
// Payload type is a parameter; types come from i2cm_pkg.
interface i2cm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/i2c_master_transaction_engine.sv */
// I2C master transaction engine, top level.
// Requests enter on cmd: action 0 tick advances one bus phase, 1 pushes a write
// byte into the queue, 2 starts a transaction (address, direction, byte count).
// Every request gives exactly one result on rsp: open-drain SCL/SDA levels for
// the phase, busy, received byte with its valid flag, done with status, and the
// queue fill. SDA is sampled from the tick request that follows SCL high.
// A taken request waits in the request register; its result is written to the result
// register when rsp can accept it. Throughput: one request per cycle while rsp is
// taken, set by the single phase step between the request and result registers.
// A stalled result holds; one more request is still taken into the request
// register, after which cmd.ready drops until rsp is taken.
// Reset (rst, synchronous) returns to idle with both lines released and an
// empty queue; queue memory contents are not cleared.
// Depends on i2cm_pkg, i2cm_stream_if, i2cm_fifo and i2cm_ctrl.
module i2c_master_transaction_engine #(
  parameter int FIFO_DEPTH = i2cm_pkg::FIFO_DEPTH
) (
  input logic           clk,
  input logic           rst,
  i2cm_stream_if.sink   cmd,
  i2cm_stream_if.source rsp
);
  localparam int FW = $clog2(FIFO_DEPTH + 1);

  i2cm_pkg::cmd_t cmd_q;
  logic           cmd_q_valid;
  i2cm_pkg::rsp_t rsp_q;
  logic           rsp_valid;
  i2cm_pkg::rsp_t ctrl_res;
  logic           step;
  logic           pop;
  logic           push;
  logic [FW-1:0]  fill;
  logic [7:0]     head_data;

  assign step      = cmd_q_valid && (!rsp_valid || rsp.ready);
  assign cmd.ready = !cmd_q_valid || step;
  assign push      = step && (cmd_q.action == i2cm_pkg::ACT_PUSH);

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_q;

  i2cm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_q.data_byte),
    .pop       (step && pop),
    .fill      (fill),
    .head_data (head_data)
  );

  i2cm_ctrl #(
    .DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (cmd_q),
    .fill      (fill),
    .head_data (head_data),
    .pop       (pop),
    .res       (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.ready) begin
        cmd_q_valid <= cmd.valid;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q <= cmd.payload;
    end
    if (step) begin
      rsp_q <= ctrl_res;
    end
  end
endmodule

/* rtl/i2cm_fifo.sv */
// Write byte queue: circular memory with head pointer and fill count.
// Head entry is read through a registered port. Depends on nothing else.
module i2cm_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [7:0]                 push_data,
  input  logic                       pop,
  output logic [$clog2(DEPTH+1)-1:0] fill,
  output logic [7:0]                 head_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = FW + 1;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_inc;
  logic [FW-1:0] fill_next;
  logic [SW-1:0] wr_sum;
  logic [SW-1:0] wr_wrap;
  logic [AW-1:0] wr_idx;
  logic          push_ok;

  assign push_ok = push && (fill < FW'(DEPTH));
  assign wr_sum  = SW'(head) + SW'(fill);
  assign wr_wrap = (wr_sum >= SW'(DEPTH)) ? (wr_sum - SW'(DEPTH)) : wr_sum;
  assign wr_idx  = wr_wrap[AW-1:0];
  assign head_inc = (SW'(head) + SW'(1) == SW'(DEPTH)) ? '0 : head + AW'(1);

  always_comb begin
    fill_next = fill;
    if (push_ok) begin
      fill_next = fill + FW'(1);
    end else if (pop && fill != '0) begin
      fill_next = fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (pop && fill != '0) begin
        head <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_idx] <= push_data;
    end
    head_data <= mem[head];
  end
endmodule

/* rtl/i2cm_ctrl.sv */
// Bus phase sequencer: one phase per tick request, START/address/data/ACK/STOP.
// Uses i2cm_pkg codes and types; pops write bytes from i2cm_fifo.
`include "i2c_master_transaction_engine_assert.svh"
module i2cm_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  i2cm_pkg::cmd_t             item,
  input  logic [$clog2(DEPTH+1)-1:0] fill,
  input  logic [7:0]                 head_data,
  output logic                       pop,
  output i2cm_pkg::rsp_t             res
);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > 8) ? FW : 8;

  logic [4:0] phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       reading, reading_next;
  logic       addr_flag, addr_flag_next;
  logic [1:0] err_code, err_code_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;

  logic [CW-1:0] fill_ext;
  logic [CW-1:0] level_ext;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] left_ext;
  logic [3:0]    bit_inc;
  logic [7:0]    rx_shift;
  logic          txbit;
  logic          mbit;
  logic          is_tick;

  assign fill_ext      = CW'(fill);
  assign cnt_ext       = CW'(item.byte_count);
  assign left_ext      = CW'(bytes_left);
  assign bit_inc       = bit_index + 4'd1;
  assign rx_shift      = {shift_byte[6:0], item.sda_in};
  assign txbit         = shift_byte[7];
  assign mbit          = (bytes_left == 8'd0);
  assign is_tick       = (item.action == i2cm_pkg::ACT_TICK);

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    bytes_left_next = bytes_left;
    reading_next    = reading;
    addr_flag_next  = addr_flag;
    err_code_next   = err_code;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    pop             = 1'b0;
    res             = '0;

    if (item.action == i2cm_pkg::ACT_START) begin
      if (phase == i2cm_pkg::PH_IDLE) begin
        if ((item.read_not_write && item.byte_count == 8'd0) ||
            (!item.read_not_write && cnt_ext > fill_ext)) begin
          res.done_res = 1'b1;
          res.status   = i2cm_pkg::ST_BAD_LEN;
        end else begin
          shift_byte_next = {item.dev_address, item.read_not_write};
          bytes_left_next = item.byte_count;
          reading_next    = item.read_not_write;
          addr_flag_next  = 1'b1;
          err_code_next   = i2cm_pkg::ST_OK;
          bit_index_next  = 4'd0;
          phase_next      = i2cm_pkg::PH_S1;
        end
      end
    end else if (is_tick) begin
      unique case (phase)
        i2cm_pkg::PH_S1: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1; phase_next = i2cm_pkg::PH_S2;
        end
        i2cm_pkg::PH_S2: begin
          scl_level_next = 1'b1; sda_level_next = 1'b0; phase_next = i2cm_pkg::PH_S3;
        end
        i2cm_pkg::PH_S3: begin
          scl_level_next = 1'b0; sda_level_next = 1'b0; phase_next = i2cm_pkg::PH_S4;
        end
        i2cm_pkg::PH_S4: begin
          scl_level_next = 1'b0; sda_level_next = 1'b1;
          bit_index_next = 4'd0;
          phase_next     = i2cm_pkg::PH_TX_SETUP;
        end
        i2cm_pkg::PH_TX_SETUP: begin
          scl_level_next = 1'b0; sda_level_next = txbit; phase_next = i2cm_pkg::PH_TX_HIGH;
        end
        i2cm_pkg::PH_TX_HIGH: begin
          scl_level_next = 1'b1; sda_level_next = txbit; phase_next = i2cm_pkg::PH_TX_LOW;
        end
        i2cm_pkg::PH_TX_LOW: begin
          scl_level_next = 1'b0; sda_level_next = txbit; phase_next = i2cm_pkg::PH_TX_REL;
        end
        i2cm_pkg::PH_TX_REL: begin
          scl_level_next  = 1'b0; sda_level_next = 1'b1;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_inc;
          phase_next      = bit_inc[3] ? i2cm_pkg::PH_ACK_HIGH : i2cm_pkg::PH_TX_SETUP;
        end
        i2cm_pkg::PH_ACK_HIGH: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1; phase_next = i2cm_pkg::PH_ACK_LOW;
        end
        i2cm_pkg::PH_ACK_LOW: begin
          scl_level_next = 1'b0; sda_level_next = 1'b1;
          if (item.sda_in) begin
            err_code_next = addr_flag ? i2cm_pkg::ST_ADDR_NACK : i2cm_pkg::ST_DATA_NACK;
            phase_next    = i2cm_pkg::PH_P1;
          end else if (addr_flag && reading) begin
            addr_flag_next  = 1'b0;
            bit_index_next  = 4'd0;
            shift_byte_next = 8'd0;
            phase_next      = i2cm_pkg::PH_RX_HIGH;
          end else begin
            addr_flag_next = 1'b0;
            if (bytes_left == 8'd0) begin
              phase_next = i2cm_pkg::PH_P1;
            end else begin
              pop             = 1'b1;
              shift_byte_next = (fill != '0) ? head_data : 8'd0;
              bytes_left_next = bytes_left - 8'd1;
              bit_index_next  = 4'd0;
              phase_next      = i2cm_pkg::PH_TX_SETUP;
            end
          end
        end
        i2cm_pkg::PH_RX_HIGH: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1; phase_next = i2cm_pkg::PH_RX_LOW;
        end
        i2cm_pkg::PH_RX_LOW: begin
          scl_level_next  = 1'b0; sda_level_next = 1'b1;
          shift_byte_next = rx_shift;
          bit_index_next  = bit_inc;
          if (bit_inc[3]) begin
            res.read_byte  = rx_shift;
            res.read_valid = 1'b1;
            if (bytes_left != 8'd0) begin
              bytes_left_next = bytes_left - 8'd1;
            end
            phase_next = i2cm_pkg::PH_MA_SETUP;
          end else begin
            phase_next = i2cm_pkg::PH_RX_HIGH;
          end
        end
        i2cm_pkg::PH_MA_SETUP: begin
          scl_level_next = 1'b0; sda_level_next = mbit; phase_next = i2cm_pkg::PH_MA_HIGH;
        end
        i2cm_pkg::PH_MA_HIGH: begin
          scl_level_next = 1'b1; sda_level_next = mbit; phase_next = i2cm_pkg::PH_MA_LOW;
        end
        i2cm_pkg::PH_MA_LOW: begin
          scl_level_next = 1'b0; sda_level_next = mbit; phase_next = i2cm_pkg::PH_MA_REL;
        end
        i2cm_pkg::PH_MA_REL: begin
          scl_level_next = 1'b0; sda_level_next = 1'b1;
          if (bytes_left == 8'd0) begin
            phase_next = i2cm_pkg::PH_P1;
          end else begin
            bit_index_next  = 4'd0;
            shift_byte_next = 8'd0;
            phase_next      = i2cm_pkg::PH_RX_HIGH;
          end
        end
        i2cm_pkg::PH_P1: begin
          scl_level_next = 1'b0; sda_level_next = 1'b0; phase_next = i2cm_pkg::PH_P2;
        end
        i2cm_pkg::PH_P2: begin
          scl_level_next = 1'b1; sda_level_next = 1'b0; phase_next = i2cm_pkg::PH_P3;
        end
        i2cm_pkg::PH_P3: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1;
          res.done_res   = 1'b1;
          res.status     = err_code;
          err_code_next  = i2cm_pkg::ST_OK;
          phase_next     = i2cm_pkg::PH_IDLE;
        end
        default: begin
          // idle or unused code: release both lines
          scl_level_next = 1'b1; sda_level_next = 1'b1;
          phase_next     = i2cm_pkg::PH_IDLE;
        end
      endcase
    end

    // queue level after this request: push or pop applied to the current fill
    level_ext = fill_ext;
    if (item.action == i2cm_pkg::ACT_PUSH && fill_ext < CW'(DEPTH)) begin
      level_ext = fill_ext + CW'(1);
    end else if (pop && fill != '0) begin
      level_ext = fill_ext - CW'(1);
    end

    res.scl_out    = scl_level_next;
    res.sda_out    = sda_level_next;
    res.busy_res   = (phase_next != i2cm_pkg::PH_IDLE);
    res.fifo_level = level_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cm_pkg::PH_IDLE;
      bit_index  <= 4'd0;
      shift_byte <= 8'd0;
      bytes_left <= 8'd0;
      reading    <= 1'b0;
      addr_flag  <= 1'b0;
      err_code   <= i2cm_pkg::ST_OK;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      bytes_left <= bytes_left_next;
      reading    <= reading_next;
      addr_flag  <= addr_flag_next;
      err_code   <= err_code_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
    end
  end

  `I2CM_ASSERT_NEXT(a_stop_to_idle, step && is_tick && phase == i2cm_pkg::PH_P3, phase == i2cm_pkg::PH_IDLE)
  `I2CM_ASSERT_NOW(a_write_covered, phase != i2cm_pkg::PH_IDLE && !reading, left_ext <= fill_ext)
  `I2CM_ASSERT_NOW(a_pop_phase, step && pop, phase == i2cm_pkg::PH_ACK_LOW && fill != '0)
  `I2CM_ASSERT_NOW(a_rx_only_read, step && res.read_valid, reading && !addr_flag)
endmodule
